/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: invariant");

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/smsrng_pkg.sv */
package smsrng_pkg;

	localparam logic [14:0] LCG_MUL = 15'd16807;
	localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic signed [31:0] SEED_OFFSET = 32'sd22261048;
	localparam logic signed [31:0] SEED_LIMIT = 32'sd1000;
	localparam int WARMUP_STEPS = 8;

	typedef struct packed {
		logic init_start;
		logic init_seed;
		logic fill_step;
		logic draw_div;
		logic draw_fix;
		logic draw_swap;
	} smsrng_cmd_t;

	typedef struct packed {
		logic lcg_zero;
		logic last_zero;
		logic fill_done;
	} smsrng_sts_t;

endpackage

/* rtl/smsrng_ram.sv */
module smsrng_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/smsrng_dp.sv */
module smsrng_dp import smsrng_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_wr_en,
	input  logic signed [31:0] seed_wr_data,
	input  smsrng_cmd_t        cmd,
	output smsrng_sts_t        sts,
	output logic [30:0]        value
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + WARMUP_STEPS);
	localparam logic [31:0] SLOT_DIV = 32'(1 + (64'd2147483646 / TABLE_DEPTH));
	localparam logic [30:0] SLOT_RECIP = 31'(64'h8000_0000 / SLOT_DIV);

	logic signed [31:0] seed_q;
	logic [31:0]        lcg_q;
	logic [30:0]        last_q;
	logic [30:0]        value_q;
	logic [CW-1:0]      cnt_q;
	logic [61:0]        div_prod_q;
	logic [AW-1:0]      slot_q;

	logic [46:0]   mul_prod;
	logic [31:0]   fold;
	logic [30:0]   lcg_next;
	logic [31:0]   seed_start;
	logic [31:0]   start_val;
	logic [AW-1:0] q_est;
	logic [31:0]   q_back;
	logic [31:0]   q_rem;
	logic [AW-1:0] slot;
	logic          fill_wr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [30:0]   ram_wdata;
	logic [30:0]   ram_rdata;

	// One generator step. 2^31 is congruent to 1, so the high part folds onto
	// the low part and one conditional subtract finishes the reduction.
	assign mul_prod = 47'(lcg_q) * 47'(LCG_MUL);
	assign fold     = {1'b0, mul_prod[30:0]} + 32'(mul_prod[46:31]);
	assign lcg_next = (fold >= {1'b0, LCG_MOD}) ? 31'(fold - {1'b0, LCG_MOD}) : fold[30:0];

	// Conditioned seed, mapped onto the start value (negated only when at or below -SEED_LIMIT).
	always_comb begin
		if (seed_q > SEED_LIMIT) begin
			seed_start = seed_q;
		end else if (seed_q <= -SEED_LIMIT) begin
			seed_start = -seed_q;
		end else if (seed_q == 32'sd0) begin
			seed_start = SEED_OFFSET - 32'sd1;
		end else begin
			seed_start = SEED_OFFSET - seed_q;
		end
	end

	assign start_val = cmd.init_seed ? seed_start : 32'd1;

	// The reciprocal estimate is exact or one low; the remainder check fixes it.
	assign q_est = div_prod_q[31 +: AW];
	assign q_back = 32'(q_est) * SLOT_DIV;
	assign q_rem = {1'b0, last_q} - q_back;
	assign slot = q_est + AW'(q_rem >= SLOT_DIV);

	assign fill_wr   = cmd.fill_step && (cnt_q < CW'(TABLE_DEPTH));
	assign ram_we    = fill_wr || cmd.draw_swap;
	assign ram_waddr = cmd.fill_step ? cnt_q[AW-1:0] : slot_q;
	assign ram_wdata = cmd.fill_step ? lcg_next : lcg_q[30:0];

	smsrng_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.draw_fix),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			lcg_q  <= '0;
			last_q <= '0;
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			if (cmd.init_start) begin
				lcg_q <= start_val;
			end else if (cmd.fill_step || cmd.draw_div) begin
				lcg_q <= {1'b0, lcg_next};
			end
			if (cmd.fill_step && (cnt_q == '0)) begin
				last_q <= lcg_next;
			end else if (cmd.draw_swap) begin
				last_q <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_start) begin
			cnt_q <= CW'(TABLE_DEPTH + WARMUP_STEPS - 1);
		end else if (cmd.fill_step) begin
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.draw_div) begin
			div_prod_q <= 62'(last_q) * 62'(SLOT_RECIP);
		end
		if (cmd.draw_fix) begin
			slot_q <= slot;
		end
		if (cmd.draw_swap) begin
			value_q <= ram_rdata;
		end
	end

	assign sts.lcg_zero  = (lcg_q == '0);
	assign sts.last_zero = (last_q == '0);
	assign sts.fill_done = (cnt_q == '0);
	assign value = value_q;

endmodule

/* rtl/smsrng_ctrl.sv */
module smsrng_ctrl import smsrng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	input  smsrng_sts_t sts,
	output smsrng_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FILL = 5'b00010,
		S_DIV  = 5'b00100,
		S_FIX  = 5'b01000,
		S_SWAP = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        needs_init_q;
	logic        out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (restart) begin
						cmd.init_start = 1'b1;
						cmd.init_seed  = 1'b1;
						state_d        = S_FILL;
					end else if (needs_init_q || sts.lcg_zero || sts.last_zero) begin
						cmd.init_start = 1'b1;
						state_d        = S_FILL;
					end else begin
						state_d = S_DIV;
					end
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_done) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.draw_div = 1'b1;
				state_d      = S_FIX;
			end
			S_FIX: begin
				cmd.draw_fix = 1'b1;
				state_d      = S_SWAP;
			end
			S_SWAP: begin
				// The table swap waits until the output register can take the result.
				if (!out_valid_q || !out_stall) begin
					cmd.draw_swap = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			needs_init_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fill_step && sts.fill_done) begin
				needs_init_q <= 1'b0;
			end
			if (cmd.draw_swap) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/shuffled_minimal_standard_rng.sv */
// An ordinary draw steps through accept (S_IDLE), slot divide (S_DIV), table read (S_FIX)
// and table swap (S_SWAP); out_valid is registered from the swap. in_stall holds new
// draws off until S_IDLE, and a stalled output holds the swap, and so the next accept,
// back. A draw that reinitializes (after reset, restart, or a zero state) first warms up
// and fills the table in S_FILL, one generator step per cycle.
// Reset (arst_n low) clears the seed, generator and control state; the shuffle
// table is not cleared and is always filled before its first read.
`include "assert_macros.svh"

module shuffled_minimal_standard_rng import smsrng_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_wr_en,
	input  logic signed [31:0] seed_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        value
);

	smsrng_cmd_t cmd;
	smsrng_sts_t sts;
	logic [4:0]  cmd_steps;

	smsrng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	smsrng_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_wr_en  (seed_wr_en),
		.seed_wr_data(seed_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value)
	);

	assign cmd_steps = {cmd.init_start, cmd.fill_step, cmd.draw_div, cmd.draw_fix, cmd.draw_swap};

	`ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_steps))
	`ASSERT_IMPL(a_swap_has_room, cmd.draw_swap, !out_valid || !out_stall)
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ASSERT_NEXT(a_fill_then_draw, cmd.fill_step && sts.fill_done, cmd.draw_div)

endmodule
